// ----- design/ihexdec_pkg.sv -----
package ihexdec_pkg;

   localparam int unsigned CharWidth = 8;
   localparam int unsigned ByteWidth = 8;
   localparam int unsigned CountWidth = 9;
   localparam int unsigned NibbleWidth = 4;
   localparam int unsigned EndRunLength = 8;
   localparam int unsigned EndIdxWidth = $clog2(EndRunLength);
   localparam int unsigned QueueDepthDefault = 4;

   localparam logic [CharWidth-1:0] ColonChar = 8'h3A;
   localparam logic [ByteWidth-1:0] KindData = 8'h00;
   localparam logic [ByteWidth-1:0] KindEnd = 8'h01;
   localparam logic [CountWidth-1:0] AddrDigits = 9'd4;
   localparam logic [CountWidth-1:0] CsumDigits = 9'd2;

   typedef enum logic [2:0] {
      PH_HUNT,
      PH_COUNT,
      PH_ADDR,
      PH_TYPE,
      PH_DATA,
      PH_CSUM
   } phase_type;

   // work item handed from the parser to the output sequencer
   typedef struct packed {
      logic                 is_end;
      logic [ByteWidth-1:0] data;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [NibbleWidth-1:0] hex_value(input logic [CharWidth-1:0] c);
      logic [NibbleWidth-1:0] v;
      v = '0;
      if (c >= 8'h30 && c <= 8'h39) begin
         v = NibbleWidth'(c - 8'h30);
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = NibbleWidth'(c - 8'h57);
      end else if (c >= 8'h41 && c <= 8'h46) begin
         v = NibbleWidth'(c - 8'h37);
      end
      return v;
   endfunction

   // fixed byte run produced by an end-of-file record
   function automatic logic [ByteWidth-1:0] end_byte(input logic [EndIdxWidth-1:0] idx);
      logic [ByteWidth-1:0] b;
      unique case (idx)
         3'd0:    b = 8'h04;
         3'd2:    b = 8'h22;
         default: b = 8'h00;
      endcase
      return b;
   endfunction

endpackage

// ----- design/ihexdec_front.sv -----
module ihexdec_front (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [7:0]                  req_char_in,
   input  ihexdec_pkg::queue_status_type q_status,
   output logic                        push,
   output ihexdec_pkg::cmd_type        push_cmd
);
   import ihexdec_pkg::*;

   phase_type              phase_ff, phase_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [ByteWidth-1:0]   length_ff, length_in;
   logic [NibbleWidth-1:0] high_ff, high_in;

   logic                   accept;
   logic [NibbleWidth-1:0] digit;
   logic [CountWidth-1:0]  count_inc;
   logic [ByteWidth-1:0]   pair;

   assign req_ready = !q_status.full;
   assign accept    = req_valid && req_ready;
   assign digit     = hex_value(req_char_in);
   assign count_inc = count_ff + CountWidth'(1);
   assign pair      = {high_ff, digit};

   always_comb begin
      phase_in  = phase_ff;
      count_in  = count_ff;
      length_in = length_ff;
      high_in   = high_ff;
      push      = 1'b0;
      push_cmd  = '0;
      if (accept) begin
         unique case (phase_ff)
            PH_COUNT: begin
               if (count_ff == '0) begin
                  high_in  = digit;
                  count_in = CountWidth'(1);
               end else begin
                  length_in = pair;
                  phase_in  = PH_ADDR;
                  count_in  = '0;
               end
            end
            PH_ADDR: begin
               if (count_inc >= AddrDigits) begin
                  phase_in = PH_TYPE;
                  count_in = '0;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_TYPE: begin
               if (count_ff == '0) begin
                  high_in  = digit;
                  count_in = CountWidth'(1);
               end else begin
                  count_in = '0;
                  if (pair == KindData) begin
                     phase_in = (length_ff != '0) ? PH_DATA : PH_CSUM;
                  end else if (pair == KindEnd) begin
                     push            = 1'b1;
                     push_cmd.is_end = 1'b1;
                     phase_in        = PH_HUNT;
                  end else begin
                     phase_in = PH_HUNT;
                  end
               end
            end
            PH_DATA: begin
               if (!count_ff[0]) begin
                  high_in = digit;
               end else begin
                  push          = 1'b1;
                  push_cmd.data = pair;
               end
               if (count_inc >= {length_ff, 1'b0}) begin
                  phase_in = PH_CSUM;
                  count_in = '0;
               end else begin
                  count_in = count_inc;
               end
            end
            PH_CSUM: begin
               if (count_inc >= CsumDigits) begin
                  phase_in = PH_HUNT;
                  count_in = '0;
               end else begin
                  count_in = count_inc;
               end
            end
            default: begin
               if (req_char_in == ColonChar) begin
                  phase_in = PH_COUNT;
                  count_in = '0;
               end else begin
                  phase_in = PH_HUNT;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         count_ff  <= '0;
         length_ff <= '0;
         high_ff   <= '0;
      end else begin
         phase_ff  <= phase_in;
         count_ff  <= count_in;
         length_ff <= length_in;
         high_ff   <= high_in;
      end
   end

endmodule

// ----- design/ihexdec_queue.sv -----
module ihexdec_queue #(
   parameter int unsigned Depth = ihexdec_pkg::QueueDepthDefault
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  ihexdec_pkg::cmd_type           push_cmd,
   input  logic                           pop,
   output ihexdec_pkg::cmd_type           head_cmd,
   output ihexdec_pkg::queue_status_type  status,
   output logic [$clog2(Depth+1)-1:0]     fill
);
   import ihexdec_pkg::*;

   localparam int unsigned PtrWidth = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int unsigned FillWidth = $clog2(Depth+1);
   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(Depth - 1);

   cmd_type               slots_ff [Depth];
   logic [PtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FillWidth-1:0]  fill_ff, fill_in;
   logic                  do_push, do_pop;

   assign status.full  = (fill_ff == FillWidth'(Depth));
   assign status.empty = (fill_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign head_cmd     = slots_ff[rd_ptr_ff];
   assign fill         = fill_ff;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + PtrWidth'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + PtrWidth'(1);
      end
      if (do_push && !do_pop) begin
         fill_in = fill_ff + FillWidth'(1);
      end else if (do_pop && !do_push) begin
         fill_in = fill_ff - FillWidth'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

endmodule

// ----- design/ihexdec_back.sv -----
module ihexdec_back (
   input  logic                          clock,
   input  logic                          reset,
   input  ihexdec_pkg::queue_status_type q_status,
   input  ihexdec_pkg::cmd_type          head_cmd,
   output logic                          pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [7:0]                    rsp_out_byte,
   output logic                          rsp_from_end_record,
   output logic                          rsp_last_of_run
);
   import ihexdec_pkg::*;

   localparam logic [EndIdxWidth-1:0] LastIdx = EndIdxWidth'(EndRunLength - 1);

   logic                   valid_ff, valid_in;
   logic [ByteWidth-1:0]   byte_ff, byte_in;
   logic                   end_ff, end_in;
   logic                   last_ff, last_in;
   logic                   run_ff, run_in;
   logic [EndIdxWidth-1:0] idx_ff, idx_in;
   logic                   load;

   assign load = !valid_ff || rsp_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      end_in   = end_ff;
      last_in  = last_ff;
      run_in   = run_ff;
      idx_in   = idx_ff;
      pop      = 1'b0;
      if (load) begin
         if (run_ff) begin
            valid_in = 1'b1;
            byte_in  = end_byte(idx_ff);
            end_in   = 1'b1;
            last_in  = (idx_ff == LastIdx);
            run_in   = (idx_ff != LastIdx);
            idx_in   = idx_ff + EndIdxWidth'(1);
         end else if (!q_status.empty) begin
            pop      = 1'b1;
            valid_in = 1'b1;
            if (head_cmd.is_end) begin
               byte_in = end_byte('0);
               end_in  = 1'b1;
               last_in = 1'b0;
               run_in  = 1'b1;
               idx_in  = EndIdxWidth'(1);
            end else begin
               byte_in = head_cmd.data;
               end_in  = 1'b0;
               last_in = 1'b1;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         run_ff   <= 1'b0;
         idx_ff   <= '0;
      end else begin
         valid_ff <= valid_in;
         run_ff   <= run_in;
         idx_ff   <= idx_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff <= byte_in;
      end_ff  <= end_in;
      last_ff <= last_in;
   end

   assign rsp_valid           = valid_ff;
   assign rsp_out_byte        = byte_ff;
   assign rsp_from_end_record = end_ff;
   assign rsp_last_of_run     = last_ff;

endmodule

// ----- design/intel_hex_record_decoder.sv -----
// intel hex record decoder: takes one ascii character per transfer on req_ and emits
// decoded bytes on rsp_. characters are dropped until a colon, then the record header
// (count, address, type) is parsed; data records give one byte per digit pair, an end
// record gives the fixed run 04 00 22 00 00 00 00 00 with only the eighth byte marked
// last, other record types give nothing. the checksum is skipped, not verified. a
// parser front end takes one character every cycle and posts byte or end-run jobs to
// a QueueDepth-entry queue; the back end drains one result per cycle, unless rsp_ready
// stalls it, into a registered output stage. so the input runs at one character per
// cycle as long as the queue has room; an end record occupies the output for its run
// of eight bytes, which without output stalls ends before the next record can post a
// job, so only a stalled output fills the queue and holds req_ready low. with the queue
// empty, a completed byte is written to the queue, then loaded into the output stage.
module intel_hex_record_decoder #(
   parameter int unsigned QueueDepth = ihexdec_pkg::QueueDepthDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_char_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_from_end_record,
   output logic       rsp_last_of_run
);
   import ihexdec_pkg::*;

   localparam int unsigned FillWidth = $clog2(QueueDepth+1);

   // parser to queue
   logic             push;
   cmd_type          push_cmd;
   // queue to output sequencer
   logic             pop;
   cmd_type          head_cmd;
   queue_status_type q_status;
   logic [FillWidth-1:0] q_fill;

   // front end: header parsing and byte assembly
   ihexdec_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_char_in (req_char_in),
      .q_status    (q_status),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // job queue decoupling parsing from result delivery
   ihexdec_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head_cmd (head_cmd),
      .status   (q_status),
      .fill     (q_fill)
   );

   // back end: expands jobs into result transfers
   ihexdec_back u_back (
      .clock               (clock),
      .reset               (reset),
      .q_status            (q_status),
      .head_cmd            (head_cmd),
      .pop                 (pop),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_from_end_record (rsp_from_end_record),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   // data bytes always close their own run
   a_data_is_last : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_from_end_record |-> rsp_last_of_run)
      else $error("data byte without last_of_run");

   // an end run continues without gaps once started
   a_end_run_contiguous : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_from_end_record && !rsp_last_of_run
      |=> rsp_valid && rsp_from_end_record)
      else $error("end run interrupted");

   // the parser never pushes into a full queue
   a_no_overflow : assert property (@(posedge clock) disable iff (reset)
      push |-> !q_status.full && q_fill < FillWidth'(QueueDepth))
      else $error("queue overflow");

endmodule

// ----- sim/tb_top.sv -----
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   import ihexdec_pkg::*;

   // one decoded byte as it should leave the rsp_ channel
   typedef struct {
      logic [7:0] data_byte;
      logic       end_flag;
      logic       last_flag;
   } hex_byte_type;

   // one character waiting to be offered, optionally only once the output has drained
   typedef struct {
      logic [7:0] ch;
      bit         wait_drain;
   } pending_char_type;

   // fixed run that an end-of-file record turns into
   localparam logic [7:0] EofRun [8] = '{8'h04, 8'h00, 8'h22, 8'h00,
                                         8'h00, 8'h00, 8'h00, 8'h00};

   logic       clock;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_char_in = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_from_end_record;
   logic       rsp_last_of_run;

   // character stream and decoded bytes still owed by the block
   pending_char_type char_q[$];
   hex_byte_type     expected_bytes[$];

   // shadow of the record parser
   phase_type  parse_phase = PH_HUNT;
   logic [8:0] digit_cnt = '0;
   logic [7:0] rec_len = '0;
   logic [7:0] rec_kind = '0;
   logic [3:0] upper_nib = '0;

   // traffic shaping
   int  err_count = 0;
   int  chars_accepted = 0;
   int  bytes_received = 0;
   int  send_gap = 0;
   int  send_gap_pct = 20;
   int  recv_gap = 0;
   int  recv_stall_pct = 20;
   bit  drain_next = 1'b0;
   logic quiet_tail = 1'b0;
   logic hold_long = 1'b0;

   intel_hex_record_decoder uut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_char_in         (req_char_in),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_out_byte        (rsp_out_byte),
      .rsp_from_end_record (rsp_from_end_record),
      .rsp_last_of_run     (rsp_last_of_run)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   task automatic report_mismatch(input string what);
      $display("mismatch at %0t ns: %s", $time, what);
      err_count++;
   endtask

   // ascii hex digit to nibble, anything else reads as zero
   function automatic logic [3:0] char_nibble(input logic [7:0] ch);
      logic [3:0] nib;
      nib = 4'h0;
      if (ch >= "0" && ch <= "9") begin
         nib = 4'(ch - "0");
      end else if (ch >= "a" && ch <= "f") begin
         nib = 4'(ch - "a" + 10);
      end else if (ch >= "A" && ch <= "F") begin
         nib = 4'(ch - "A" + 10);
      end
      return nib;
   endfunction

   // advance the shadow parser by one character and queue what it yields
   task automatic decode_char(input logic [7:0] ch);
      logic [3:0]   nib;
      hex_byte_type b;
      int           k;
      nib = char_nibble(ch);
      case (parse_phase)
         PH_COUNT: begin
            if (digit_cnt == 0) begin
               upper_nib = nib;
               digit_cnt = 9'd1;
            end else begin
               rec_len = {upper_nib, nib};
               parse_phase = PH_ADDR;
               digit_cnt = '0;
            end
         end
         PH_ADDR: begin
            digit_cnt = digit_cnt + 9'd1;
            if (digit_cnt >= AddrDigits) begin
               parse_phase = PH_TYPE;
               digit_cnt = '0;
            end
         end
         PH_TYPE: begin
            if (digit_cnt == 0) begin
               upper_nib = nib;
               digit_cnt = 9'd1;
            end else begin
               rec_kind = {upper_nib, nib};
               digit_cnt = '0;
               if (rec_kind == KindData) begin
                  // zero-length data goes straight to the checksum
                  parse_phase = (rec_len != 0) ? PH_DATA : PH_CSUM;
               end else if (rec_kind == KindEnd) begin
                  for (k = 0; k < EndRunLength; k++) begin
                     b.data_byte = EofRun[k];
                     b.end_flag = 1'b1;
                     b.last_flag = (k == EndRunLength - 1);
                     expected_bytes.push_back(b);
                  end
                  parse_phase = PH_HUNT;
               end else begin
                  parse_phase = PH_HUNT;
               end
            end
         end
         PH_DATA: begin
            if (!digit_cnt[0]) begin
               upper_nib = nib;
            end else begin
               b.data_byte = {upper_nib, nib};
               b.end_flag = 1'b0;
               b.last_flag = 1'b1;
               expected_bytes.push_back(b);
            end
            digit_cnt = digit_cnt + 9'd1;
            if (digit_cnt >= {rec_len, 1'b0}) begin
               parse_phase = PH_CSUM;
               digit_cnt = '0;
            end
         end
         PH_CSUM: begin
            digit_cnt = digit_cnt + 9'd1;
            if (digit_cnt >= CsumDigits) begin
               parse_phase = PH_HUNT;
               digit_cnt = '0;
            end
         end
         default: begin
            if (ch == ColonChar) begin
               parse_phase = PH_COUNT;
               digit_cnt = '0;
            end else begin
               parse_phase = PH_HUNT;
            end
         end
      endcase
   endtask

   // stimulus building
   task automatic push_char(input logic [7:0] ch);
      pending_char_type p;
      p.ch = ch;
      p.wait_drain = drain_next;
      drain_next = 1'b0;
      char_q.push_back(p);
   endtask

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++) begin
         push_char(s[i]);
      end
   endtask

   function automatic logic [7:0] hex_digit(input logic [3:0] v);
      logic [7:0] ch;
      if (v < 10) begin
         ch = 8'("0") + 8'(v);
      end else begin
         // either case
         ch = ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + 8'(v) - 8'd10;
      end
      return ch;
   endfunction

   // hex field, most significant digit first; noise_pct swaps digits for raw bytes
   task automatic push_field(input logic [15:0] v, input int digits, input int noise_pct);
      logic [7:0] ch;
      int         i;
      for (i = digits - 1; i >= 0; i--) begin
         ch = hex_digit(v[i*4 +: 4]);
         if ($urandom_range(0, 99) < noise_pct) begin
            ch = 8'($urandom_range(0, 255));
         end
         push_char(ch);
      end
   endtask

   task automatic add_random_record();
      int pick;
      int len;
      int i;
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
         // data record with random payload
         len = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 8);
         push_char(ColonChar);
         push_field(16'(len), 2, 0);
         push_field(16'($urandom), 4, 5);
         push_field(16'(KindData), 2, 0);
         for (i = 0; i < len; i++) begin
            push_field(16'($urandom), 2, 4);
         end
         push_field(16'($urandom), 2, 10);
      end else if (pick < 70) begin
         // end of file, any byte count
         push_char(ColonChar);
         push_field(16'($urandom_range(0, 255)), 2, 0);
         push_field(16'($urandom), 4, 5);
         push_field(16'(KindEnd), 2, 0);
         push_field(16'($urandom), 2, 10);
      end else if (pick < 85) begin
         // unhandled record type, body is skipped while hunting
         push_char(ColonChar);
         push_field(16'($urandom_range(0, 255)), 2, 0);
         push_field(16'($urandom), 4, 5);
         push_field(16'($urandom_range(2, 255)), 2, 0);
         len = $urandom_range(0, 4);
         for (i = 0; i < len; i++) begin
            push_field(16'($urandom), 2, 0);
         end
         push_field(16'($urandom), 2, 0);
      end else begin
         // raw noise, colons included, which may leave a record cut short
         len = $urandom_range(1, 6);
         for (i = 0; i < len; i++) begin
            push_char(8'($urandom_range(0, 255)));
         end
      end
      if ($urandom_range(0, 1)) begin
         push_text("\r\n");
      end else begin
         push_text("\n");
      end
   endtask

   // sender: offers the next character once the previous transfer is done
   always @(posedge clock) begin
      pending_char_type next_item;
      if (reset) begin
         req_valid <= 1'b0;
         req_char_in <= 8'h00;
      end else begin
         if (req_valid && req_ready) begin
            decode_char(req_char_in);
            chars_accepted++;
            // change the idling mix now and then, zero included
            if (chars_accepted % 64 == 0) begin
               case ($urandom_range(0, 2))
                  0: send_gap_pct = 0;
                  1: send_gap_pct = 15;
                  default: send_gap_pct = 40;
               endcase
            end
         end
         if (!req_valid || req_ready) begin
            if (send_gap != 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (char_q.size() == 0) begin
               req_valid <= 1'b0;
            end else if (char_q[0].wait_drain && expected_bytes.size() != 0) begin
               // hold until every owed byte has come out
               req_valid <= 1'b0;
            end else begin
               next_item = char_q.pop_front();
               req_valid <= 1'b1;
               req_char_in <= next_item.ch;
               if (!quiet_tail && $urandom_range(0, 99) < send_gap_pct) begin
                  send_gap = $urandom_range(1, 10);
               end
            end
         end
         quiet_tail <= (char_q.size() < 60);
      end
   end

   // receiver: checks each transfer against the oldest owed byte
   always @(posedge clock) begin
      hex_byte_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            bytes_received++;
            if (expected_bytes.size() == 0) begin
               report_mismatch($sformatf("unexpected byte %02h end=%0b last=%0b",
                  rsp_out_byte, rsp_from_end_record, rsp_last_of_run));
            end else begin
               want = expected_bytes.pop_front();
               if (rsp_out_byte !== want.data_byte) begin
                  report_mismatch($sformatf("out_byte %02h, want %02h",
                     rsp_out_byte, want.data_byte));
               end
               if (rsp_from_end_record !== want.end_flag) begin
                  report_mismatch($sformatf("from_end_record %0b, want %0b",
                     rsp_from_end_record, want.end_flag));
               end
               if (rsp_last_of_run !== want.last_flag) begin
                  report_mismatch($sformatf("last_of_run %0b, want %0b",
                     rsp_last_of_run, want.last_flag));
               end
            end
            if (bytes_received % 64 == 0) begin
               case ($urandom_range(0, 2))
                  0: recv_stall_pct = 0;
                  1: recv_stall_pct = 20;
                  default: recv_stall_pct = 50;
               endcase
            end
         end
         if (hold_long) begin
            rsp_ready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_ready <= 1'b0;
         end else if (!quiet_tail && $urandom_range(0, 99) < recv_stall_pct) begin
            recv_gap = $urandom_range(1, 10) - 1;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // long output stall so the internal queue fills and req_ready drops
   initial begin
      wait (chars_accepted >= 80);
      @(posedge clock);
      hold_long <= 1'b1;
      repeat (300) @(posedge clock);
      hold_long <= 1'b0;
   end

   // watchdog
   initial begin
      #5_000_000;
      $display("intel_hex_record_decoder regression: fail");
      $finish;
   end

   initial begin
      hex_byte_type left;
      int           directed_len;
      int           waited;

      // bytes outside a record are dropped
      push_char(8'h00);
      push_char(8'hFF);
      push_char("Z");
      // one data byte in mixed case, checksum digits not hex
      push_text(":01ABCD00aFzz");
      // end record with a colon and junk inside the address
      push_text(":00:G\n 01");
      // zero-length data record
      push_text(":0000000000");
      // unhandled type, its body is skipped while hunting
      push_text(":02000005AB");
      directed_len = char_q.size();

      // random part starts from an empty output
      drain_next = 1'b1;
      while (char_q.size() < 370) begin
         add_random_record();
         // drain pauses again half way through
         if (char_q.size() > directed_len + 185 && char_q.size() < directed_len + 215) begin
            drain_next = 1'b1;
         end
      end

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      while (char_q.size() != 0 || req_valid) @(posedge clock);
      waited = 0;
      while (expected_bytes.size() != 0 && waited < 50000) begin
         @(posedge clock);
         waited++;
      end
      // room for stray bytes to show up
      repeat (20) @(posedge clock);
      while (expected_bytes.size() != 0) begin
         left = expected_bytes.pop_front();
         report_mismatch($sformatf("missing byte %02h end=%0b last=%0b",
            left.data_byte, left.end_flag, left.last_flag));
      end
      if (err_count == 0) begin
         $display("intel_hex_record_decoder regression: pass");
      end else begin
         $display("intel_hex_record_decoder regression: fail");
      end
      $finish;
   end

endmodule
